/* hdl/jtok_pkg.sv */
// Shared types and constants of the flat JSON object tokenizer.
package jtok_pkg;

    // Parse phase of the record
    typedef enum logic [3:0] {
        PH_START,
        PH_SEP,
        PH_KEY,
        PH_COLON,
        PH_VALWAIT,
        PH_STR,
        PH_NUM,
        PH_DONE,
        PH_ERR
    } phase_t;

    typedef enum logic [2:0] {
        TK_KEY_CHAR,
        TK_KEY_END,
        TK_STR_CHAR,
        TK_STR_END,
        TK_NUMBER,
        TK_REC_END
    } token_kind_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NOT_OBJECT,
        ST_BAD_KEY,
        ST_OPEN_KEY,
        ST_NO_COLON,
        ST_OPEN_VALUE,
        ST_BAD_VALUE
    } status_t;

    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // Widest magnitude carried through the result queue
    localparam int MAG_W = 64;

    // Result queue geometry
    localparam int RQ_DEPTH = 4;
    localparam int RQ_IDX_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         token_kind;
        logic [7:0]         char_out;
        logic signed [63:0] number_value;
        logic [2:0]         status;
        logic               last_of_run;
    } out_item_t;

    // One queued result; a number is kept as magnitude plus flags
    typedef struct packed {
        token_kind_t      kind;
        logic [7:0]       chr;
        logic [MAG_W-1:0] mag;
        logic             minus;
        logic             ovf;
        status_t          status;
        logic             last;
    } res_entry_t;

    // Up to two results written into the queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        res_entry_t e0;
        res_entry_t e1;
    } rq_push_t;

    function automatic res_entry_t plain_entry(token_kind_t kind, logic [7:0] chr,
                                               status_t status, logic last);
        res_entry_t e;
        e.kind   = kind;
        e.chr    = chr;
        e.mag    = '0;
        e.minus  = 1'b0;
        e.ovf    = 1'b0;
        e.status = status;
        e.last   = last;
        return e;
    endfunction

endpackage

/* hdl/jtok_stream_if.sv */
// Valid/ready stream channel carrying one item per handshake.
interface jtok_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/jtok_core.sv */
// Parser state and per-byte token decision of the tokenizer.
module jtok_core #(
    parameter int NUMBER_WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  jtok_pkg::in_item_t item,
    output jtok_pkg::rq_push_t push
);

    localparam int PW = NUMBER_WIDTH + 4;
    localparam logic [PW-1:0] CAP_X = {4'b0, 1'b1, {(NUMBER_WIDTH-1){1'b0}}};

    jtok_pkg::phase_t        phase_reg, phase_next;
    logic [NUMBER_WIDTH-1:0] acc_reg, acc_next;
    logic                    minus_reg, minus_next;
    logic                    ovf_reg, ovf_next;
    logic                    digit_reg, digit_next;
    jtok_pkg::status_t       err_reg, err_next;

    logic [7:0]              b;
    logic                    is_digit;
    logic [3:0]              dval;
    logic                    starting;
    logic [NUMBER_WIDTH-1:0] base_acc;
    logic                    base_ovf;
    logic [PW-1:0]           prod;
    logic                    prod_ovf;
    logic                    sw_v;
    logic                    fl_v;
    jtok_pkg::res_entry_t    sw_e, fl_e, rec_e;
    jtok_pkg::status_t       st;
    jtok_pkg::phase_t        sep_ph;

    // Phase after a byte met at a separator position
    function automatic jtok_pkg::phase_t sep_phase(logic [7:0] c);
        jtok_pkg::phase_t p;
        if (c == jtok_pkg::CH_SPACE || c == jtok_pkg::CH_NEWLINE
            || c == jtok_pkg::CH_COMMA)
            p = jtok_pkg::PH_SEP;
        else if (c == jtok_pkg::CH_RBRACE)
            p = jtok_pkg::PH_DONE;
        else if (c == jtok_pkg::CH_QUOTE)
            p = jtok_pkg::PH_KEY;
        else
            p = jtok_pkg::PH_ERR;
        return p;
    endfunction

    assign b        = item.byte_in;
    assign is_digit = (b >= jtok_pkg::CH_ZERO) && (b <= jtok_pkg::CH_NINE);
    assign dval     = 4'(b - jtok_pkg::CH_ZERO);
    assign sep_ph   = sep_phase(b);

    // A digit in the value-wait phase starts a fresh accumulator
    assign starting = (phase_reg == jtok_pkg::PH_VALWAIT);
    assign base_acc = starting ? '0 : acc_reg;
    assign base_ovf = starting ? 1'b0 : ovf_reg;
    assign prod     = ({4'b0, base_acc} << 3) + ({4'b0, base_acc} << 1) + PW'(dval);
    assign prod_ovf = (prod > CAP_X);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        minus_next = minus_reg;
        ovf_next   = ovf_reg;
        digit_next = digit_reg;
        err_next   = err_reg;
        sw_v       = 1'b0;
        fl_v       = 1'b0;
        sw_e       = jtok_pkg::plain_entry(jtok_pkg::TK_KEY_CHAR, 8'h00, jtok_pkg::ST_OK,
                                           1'b0);
        fl_e       = sw_e;
        rec_e      = sw_e;
        st         = jtok_pkg::ST_OK;
        push       = '0;

        if (fire)
        begin
            case (phase_reg)
                jtok_pkg::PH_START:
                begin
                    if (b == jtok_pkg::CH_LBRACE)
                        phase_next = jtok_pkg::PH_SEP;
                    else
                    begin
                        if (err_reg == jtok_pkg::ST_OK)
                            err_next = jtok_pkg::ST_NOT_OBJECT;
                        phase_next = jtok_pkg::PH_ERR;
                    end
                end
                jtok_pkg::PH_SEP:
                begin
                    phase_next = sep_ph;
                    if (sep_ph == jtok_pkg::PH_ERR && err_reg == jtok_pkg::ST_OK)
                        err_next = jtok_pkg::ST_BAD_KEY;
                end
                jtok_pkg::PH_KEY:
                begin
                    sw_v = 1'b1;
                    if (b == jtok_pkg::CH_QUOTE)
                    begin
                        sw_e = jtok_pkg::plain_entry(jtok_pkg::TK_KEY_END, 8'h00,
                                                     jtok_pkg::ST_OK, !item.last_byte);
                        phase_next = jtok_pkg::PH_COLON;
                    end
                    else
                        sw_e = jtok_pkg::plain_entry(jtok_pkg::TK_KEY_CHAR, b,
                                                     jtok_pkg::ST_OK, !item.last_byte);
                end
                jtok_pkg::PH_COLON:
                begin
                    if (b == jtok_pkg::CH_COLON)
                        phase_next = jtok_pkg::PH_VALWAIT;
                    else if (b != jtok_pkg::CH_SPACE)
                    begin
                        if (err_reg == jtok_pkg::ST_OK)
                            err_next = jtok_pkg::ST_NO_COLON;
                        phase_next = jtok_pkg::PH_ERR;
                    end
                end
                jtok_pkg::PH_VALWAIT:
                begin
                    if (b == jtok_pkg::CH_QUOTE)
                        phase_next = jtok_pkg::PH_STR;
                    else if (b == jtok_pkg::CH_MINUS)
                    begin
                        phase_next = jtok_pkg::PH_NUM;
                        acc_next   = '0;
                        minus_next = 1'b1;
                        ovf_next   = 1'b0;
                        digit_next = 1'b0;
                    end
                    else if (is_digit)
                    begin
                        phase_next = jtok_pkg::PH_NUM;
                        minus_next = 1'b0;
                        digit_next = 1'b1;
                        acc_next   = '0;
                        ovf_next   = 1'b0;
                        if (prod_ovf)
                            ovf_next = 1'b1;
                        else
                            acc_next = prod[NUMBER_WIDTH-1:0];
                    end
                    else if (b != jtok_pkg::CH_SPACE)
                    begin
                        if (err_reg == jtok_pkg::ST_OK)
                            err_next = jtok_pkg::ST_BAD_VALUE;
                        phase_next = jtok_pkg::PH_ERR;
                    end
                end
                jtok_pkg::PH_STR:
                begin
                    sw_v = 1'b1;
                    if (b == jtok_pkg::CH_QUOTE)
                    begin
                        sw_e = jtok_pkg::plain_entry(jtok_pkg::TK_STR_END, 8'h00,
                                                     jtok_pkg::ST_OK, !item.last_byte);
                        phase_next = jtok_pkg::PH_SEP;
                    end
                    else
                        sw_e = jtok_pkg::plain_entry(jtok_pkg::TK_STR_CHAR, b,
                                                     jtok_pkg::ST_OK, !item.last_byte);
                end
                jtok_pkg::PH_NUM:
                begin
                    if (is_digit)
                    begin
                        digit_next = 1'b1;
                        if (!base_ovf)
                        begin
                            if (prod_ovf)
                                ovf_next = 1'b1;
                            else
                                acc_next = prod[NUMBER_WIDTH-1:0];
                        end
                    end
                    else if (!digit_reg)
                    begin
                        if (err_reg == jtok_pkg::ST_OK)
                            err_next = jtok_pkg::ST_BAD_KEY;
                        phase_next = jtok_pkg::PH_ERR;
                    end
                    else
                    begin
                        // Close the number, then treat this byte as a separator
                        sw_v       = 1'b1;
                        sw_e       = jtok_pkg::plain_entry(jtok_pkg::TK_NUMBER, 8'h00,
                                                           jtok_pkg::ST_OK, !item.last_byte);
                        sw_e.mag   = jtok_pkg::MAG_W'(acc_reg);
                        sw_e.minus = minus_reg;
                        sw_e.ovf   = ovf_reg;
                        phase_next = sep_ph;
                        if (sep_ph == jtok_pkg::PH_ERR && err_reg == jtok_pkg::ST_OK)
                            err_next = jtok_pkg::ST_BAD_KEY;
                    end
                end
                default:
                begin
                    // Done or failed: drop bytes until the last one
                end
            endcase

            if (item.last_byte)
            begin
                if (phase_next == jtok_pkg::PH_NUM && digit_next)
                begin
                    fl_v       = 1'b1;
                    fl_e       = jtok_pkg::plain_entry(jtok_pkg::TK_NUMBER, 8'h00,
                                                       jtok_pkg::ST_OK, 1'b0);
                    fl_e.mag   = jtok_pkg::MAG_W'(acc_next);
                    fl_e.minus = minus_next;
                    fl_e.ovf   = ovf_next;
                end

                if (b != jtok_pkg::CH_RBRACE)
                    st = jtok_pkg::ST_NOT_OBJECT;
                else if (err_next != jtok_pkg::ST_OK)
                    st = err_next;
                else if (phase_next == jtok_pkg::PH_KEY)
                    st = jtok_pkg::ST_OPEN_KEY;
                else if (phase_next == jtok_pkg::PH_COLON)
                    st = jtok_pkg::ST_NO_COLON;
                else if (phase_next == jtok_pkg::PH_VALWAIT)
                    st = jtok_pkg::ST_BAD_VALUE;
                else if (phase_next == jtok_pkg::PH_STR)
                    st = jtok_pkg::ST_OPEN_VALUE;
                else if (phase_next == jtok_pkg::PH_NUM && !digit_next)
                    st = jtok_pkg::ST_BAD_KEY;
                else if (phase_next == jtok_pkg::PH_START)
                    st = jtok_pkg::ST_NOT_OBJECT;

                rec_e = jtok_pkg::plain_entry(jtok_pkg::TK_REC_END, 8'h00, st, 1'b1);

                // Back to the idle record state
                phase_next = jtok_pkg::PH_START;
                acc_next   = '0;
                minus_next = 1'b0;
                ovf_next   = 1'b0;
                digit_next = 1'b0;
                err_next   = jtok_pkg::ST_OK;
            end

            // Pack the results of this byte in order
            push.cnt = 2'(sw_v) + 2'(fl_v) + 2'(item.last_byte);
            if (sw_v)
            begin
                push.e0 = sw_e;
                push.e1 = fl_v ? fl_e : rec_e;
            end
            else if (fl_v)
            begin
                push.e0 = fl_e;
                push.e1 = rec_e;
            end
            else
            begin
                push.e0 = rec_e;
                push.e1 = rec_e;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= jtok_pkg::PH_START;
            acc_reg   <= '0;
            minus_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            digit_reg <= 1'b0;
            err_reg   <= jtok_pkg::ST_OK;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            minus_reg <= minus_next;
            ovf_reg   <= ovf_next;
            digit_reg <= digit_next;
            err_reg   <= err_next;
        end
    end

endmodule

/* hdl/jtok_rq.sv */
// Small result queue taking up to two results per cycle, giving one.
module jtok_rq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  jtok_pkg::rq_push_t   push,
    input  logic                 pop,
    output jtok_pkg::res_entry_t head,
    output logic                 not_empty,
    output logic                 has_room
);

    jtok_pkg::res_entry_t            mem_reg [jtok_pkg::RQ_DEPTH];
    logic [jtok_pkg::RQ_IDX_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [jtok_pkg::RQ_IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [jtok_pkg::RQ_CNT_W-1:0]   count_reg, count_next;

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign has_room  = (count_reg <= jtok_pkg::RQ_CNT_W'(jtok_pkg::RQ_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + jtok_pkg::RQ_IDX_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + jtok_pkg::RQ_IDX_W'(pop);
        count_next  = count_reg + jtok_pkg::RQ_CNT_W'(push.cnt)
                      - jtok_pkg::RQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem_reg[wr_ptr_reg] <= push.e0;
        if (push.cnt == 2'd2)
            mem_reg[wr_ptr_reg + jtok_pkg::RQ_IDX_W'(1)] <= push.e1;
    end

endmodule

/* hdl/flat_json_object_tokenizer.sv */
// Top level of the flat JSON object tokenizer: byte stream in, token stream out.
// A byte's first token is registered in the result queue and offered once earlier tokens have left.
// Throughput: one byte per cycle while the result queue has room; a byte that yields two
//   tokens (a number closed at the final byte, or a token plus record end) is absorbed by
//   a four-entry result queue that takes a byte whenever two slots are free.
// Reset: asynchronous active-low; clears the parse state and empties the queue.
module flat_json_object_tokenizer #(
    parameter int NUMBER_WIDTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    jtok_stream_if.sink   in_chan,
    jtok_stream_if.source out_chan
);

    // Largest magnitude for the chosen number width (the negative limit)
    localparam logic [NUMBER_WIDTH-1:0] CAP = {1'b1, {(NUMBER_WIDTH-1){1'b0}}};

    logic                        fire;
    logic                        pop;
    logic                        not_empty;
    logic                        has_room;
    jtok_pkg::rq_push_t          push;
    jtok_pkg::res_entry_t        head;
    logic [NUMBER_WIDTH-1:0]     head_mag;
    logic signed [NUMBER_WIDTH-1:0] num_val;
    jtok_pkg::out_item_t         out_item;

    // Take a byte only while the queue can hold every token it may produce
    assign in_chan.ready = has_room;
    assign fire          = in_chan.valid && in_chan.ready;
    assign pop           = out_chan.valid && out_chan.ready;

    // Phase decision and accumulator update for each accepted byte
    jtok_core #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_chan.data),
        .push  (push)
    );

    // Results wait here, so input keeps flowing while the sink stalls until the queue fills
    jtok_rq u_rq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .has_room  (has_room)
    );

    // Saturate and sign the queued magnitude at the output
    assign head_mag = head.mag[NUMBER_WIDTH-1:0];

    always_comb
    begin
        if (head.minus)
            num_val = head.ovf ? CAP : ('0 - head_mag);
        else if (head.ovf || head_mag > (CAP - 1'b1))
            num_val = CAP - 1'b1;
        else
            num_val = head_mag;
    end

    always_comb
    begin
        out_item.token_kind   = head.kind;
        out_item.char_out     = head.chr;
        out_item.number_value = 64'(num_val);
        out_item.status       = head.status;
        out_item.last_of_run  = head.last;
    end

    assign out_chan.valid = not_empty;
    assign out_chan.data  = out_item;

    // A record end is always the final token of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_chan.valid && out_chan.data.token_kind == jtok_pkg::TK_REC_END
        |-> out_chan.data.last_of_run)
        else $error("record end token without last_of_run");

    // Only number tokens carry a value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_chan.valid && out_chan.data.token_kind != jtok_pkg::TK_NUMBER
        |-> out_chan.data.number_value == 64'sd0)
        else $error("nonzero value on a non-number token");

    // Only record end tokens carry a status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_chan.valid && out_chan.data.token_kind != jtok_pkg::TK_REC_END
        |-> out_chan.data.status == jtok_pkg::ST_OK)
        else $error("status on a token other than record end");

    // A byte is never taken while the queue is short of room for two tokens
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> has_room)
        else $error("byte accepted into a full result queue");

endmodule
